/* sv/wcs_pkg.sv */
// ----------------------------------------------------------------------------
// wcs_pkg: shared types and constants of the wash cycle sequencer
// Phase codes, phase kinds, actuator bit positions, register indexes and the
// structs passed between the top level and the step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package wcs_pkg;

  // phase codes
  typedef logic [3:0] phase_t;
  localparam phase_t PH_IDLE        = 4'd0;
  localparam phase_t PH_DRAIN_PRE   = 4'd1;
  localparam phase_t PH_FILL_PRE    = 4'd2;
  localparam phase_t PH_PREWASH     = 4'd3;
  localparam phase_t PH_DRAIN_WASH  = 4'd4;
  localparam phase_t PH_FILL_WASH   = 4'd5;
  localparam phase_t PH_WASH        = 4'd6;
  localparam phase_t PH_DRAIN_R1    = 4'd7;
  localparam phase_t PH_FILL_R1     = 4'd8;
  localparam phase_t PH_RINSE1      = 4'd9;
  localparam phase_t PH_DRAIN_R2    = 4'd10;
  localparam phase_t PH_FILL_R2     = 4'd11;
  localparam phase_t PH_RINSE2      = 4'd12;
  localparam phase_t PH_FINAL_DRAIN = 4'd13;
  localparam phase_t PH_COMPLETE    = 4'd14;
  localparam phase_t PH_ERROR       = 4'd15;

  // kind of a sequence phase
  typedef enum logic [1:0] {
    KIND_DRAIN,
    KIND_FILL,
    KIND_AGITATE,
    KIND_OTHER
  } kind_t;

  // actuator bit positions
  localparam int unsigned ACT_PUMP   = 0;
  localparam int unsigned ACT_MOTOR  = 1;
  localparam int unsigned ACT_VALVE  = 2;
  localparam int unsigned ACT_POWDER = 3;

  // widths
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DRAIN_TIME     = 3'd0;
  localparam cfg_idx_t REG_FILL_TIMEOUT   = 3'd1;
  localparam cfg_idx_t REG_PREWASH_TIME   = 3'd2;
  localparam cfg_idx_t REG_WASH_TIME      = 3'd3;
  localparam cfg_idx_t REG_RINSE_ONE_TIME = 3'd4;
  localparam cfg_idx_t REG_RINSE_TWO_TIME = 3'd5;
  localparam cfg_idx_t REG_FILL_THRESHOLD = 3'd6;
  localparam cfg_idx_t REG_POWDER_TIME    = 3'd7;

  // complete phase hold time, ms
  localparam logic [LIMIT_W-1:0] COMPLETE_WAIT = 24'd5000;

  // configuration register file contents
  typedef struct packed {
    logic [LIMIT_W-1:0] drain_time;
    logic [LIMIT_W-1:0] fill_timeout;
    logic [LIMIT_W-1:0] prewash_time;
    logic [LIMIT_W-1:0] wash_time;
    logic [LIMIT_W-1:0] rinse_one_time;
    logic [LIMIT_W-1:0] rinse_two_time;
    logic [CNT_W-1:0]   fill_pulse_threshold;
    logic [CNT_W-1:0]   powder_time;
  } cfg_t;

  // one tick
  typedef struct packed {
    logic       paused;
    logic [3:0] reed_pulses;
    logic       load_phase;
    phase_t     new_phase;
  } tick_t;

  // one result
  typedef struct packed {
    logic [3:0] act;
    phase_t     phase;
    logic       phase_advanced;
  } result_t;

  // sequencer state apart from the phase timer
  typedef struct packed {
    phase_t             code;
    logic               entered;
    logic [LIMIT_W-1:0] limit;
    logic               powder_active;
    logic [CNT_W-1:0]   powder_elapsed;
    logic [CNT_W-1:0]   pulse_count;
    logic [3:0]         act;
  } seq_state_t;

  // drain, fill or agitate for codes 1 to 13
  function automatic kind_t kind_of(input phase_t p);
    kind_t k;
    unique case (p)
      PH_DRAIN_PRE, PH_DRAIN_WASH, PH_DRAIN_R1, PH_DRAIN_R2,
      PH_FINAL_DRAIN:                                   k = KIND_DRAIN;
      PH_FILL_PRE, PH_FILL_WASH, PH_FILL_R1, PH_FILL_R2: k = KIND_FILL;
      PH_PREWASH, PH_WASH, PH_RINSE1, PH_RINSE2:        k = KIND_AGITATE;
      default:                                          k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* sv/wcs_if.sv */
// ----------------------------------------------------------------------------
// wcs_if: tick and result channels of the wash cycle sequencer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface wcs_tick_if;
  logic             valid;
  logic             ready;
  logic             paused;
  logic [3:0]       reed_pulses;
  logic             load_phase;
  wcs_pkg::phase_t  new_phase;

  modport source (output valid, paused, reed_pulses, load_phase, new_phase,
                  input ready);
  modport sink   (input valid, paused, reed_pulses, load_phase, new_phase,
                  output ready);
endinterface

interface wcs_result_if;
  logic             valid;
  logic             ready;
  logic             pump_on;
  logic             motor_on;
  logic             valve_on;
  logic             powder_on;
  wcs_pkg::phase_t  phase;
  logic             phase_advanced;

  modport source (output valid, pump_on, motor_on, valve_on, powder_on, phase,
                  phase_advanced, input ready);
  modport sink   (input valid, pump_on, motor_on, valve_on, powder_on, phase,
                  phase_advanced, output ready);
endinterface

`default_nettype wire

/* sv/wcs_step.sv */
// ----------------------------------------------------------------------------
// wcs_step: next-state logic for one millisecond tick
// Advances the timers and pulse count, applies a phase load, then runs the
// powder timeout and the phase logic when the tick is not paused.
// ----------------------------------------------------------------------------
`default_nettype none

module wcs_step #(
  parameter int unsigned TIME_BITS = 24
) (
  input  wcs_pkg::seq_state_t  state,
  input  logic [TIME_BITS-1:0] elapsed,
  input  wcs_pkg::tick_t       tick,
  input  wcs_pkg::cfg_t        cfg,
  output wcs_pkg::seq_state_t  state_next,
  output logic [TIME_BITS-1:0] elapsed_next,
  output wcs_pkg::result_t     res
);

  // compare width covers both the timer and the 24-bit limit
  localparam int unsigned CMP_W =
    (TIME_BITS > wcs_pkg::LIMIT_W) ? TIME_BITS : wcs_pkg::LIMIT_W;

  wcs_pkg::seq_state_t        st;
  logic [TIME_BITS-1:0]       el;
  logic [wcs_pkg::CNT_W:0]    pulse_sum;
  logic                       adv;
  logic                       done;
  wcs_pkg::kind_t             kind;
  logic [wcs_pkg::LIMIT_W-1:0] seq_limit;
  wcs_pkg::phase_t            code_ld;

  // phase code after an external load
  assign code_ld = tick.load_phase ? tick.new_phase : state.code;

  // limit of the current sequence phase
  always_comb begin
    unique case (code_ld)
      wcs_pkg::PH_FILL_PRE, wcs_pkg::PH_FILL_WASH,
      wcs_pkg::PH_FILL_R1, wcs_pkg::PH_FILL_R2: seq_limit = cfg.fill_timeout;
      wcs_pkg::PH_PREWASH:                      seq_limit = cfg.prewash_time;
      wcs_pkg::PH_WASH:                         seq_limit = cfg.wash_time;
      wcs_pkg::PH_RINSE1:                       seq_limit = cfg.rinse_one_time;
      wcs_pkg::PH_RINSE2:                       seq_limit = cfg.rinse_two_time;
      default:                                  seq_limit = cfg.drain_time;
    endcase
  end

  assign kind = wcs_pkg::kind_of(code_ld);

  always_comb begin
    st   = state;
    el   = elapsed;
    adv  = 1'b0;
    done = 1'b0;

    // time passes, paused or not; all counters saturate
    if (el != '1) el = el + 1'b1;
    if (st.powder_elapsed != '1) st.powder_elapsed = st.powder_elapsed + 1'b1;
    pulse_sum = {1'b0, st.pulse_count} + {{(wcs_pkg::CNT_W - 3){1'b0}}, tick.reed_pulses};
    st.pulse_count = pulse_sum[wcs_pkg::CNT_W] ? '1 : pulse_sum[wcs_pkg::CNT_W-1:0];

    // external phase load, entry flag kept
    if (tick.load_phase) st.code = tick.new_phase;

    if (!tick.paused) begin
      // powder valve timeout
      if (st.powder_active && (st.powder_elapsed >= cfg.powder_time)) begin
        st.act[wcs_pkg::ACT_POWDER] = 1'b0;
        st.powder_active = 1'b0;
      end

      priority if (st.code == wcs_pkg::PH_IDLE || st.code == wcs_pkg::PH_ERROR) begin
        if (st.entered) begin
          st.act = '0;
          st.powder_active = 1'b0;
          st.entered = 1'b0;
        end
      end else if (st.code == wcs_pkg::PH_COMPLETE) begin
        if (!st.entered) begin
          st.act = '0;
          st.powder_active = 1'b0;
          el = '0;
          st.limit = wcs_pkg::COMPLETE_WAIT;
          st.entered = 1'b1;
        end
        if (CMP_W'(el) >= CMP_W'(st.limit)) begin
          st.code = wcs_pkg::PH_IDLE;
          st.entered = 1'b0;
          adv = 1'b1;
        end
      end else begin
        // sequence phase entry
        if (!st.entered) begin
          el = '0;
          st.limit = seq_limit;
          unique case (kind)
            wcs_pkg::KIND_FILL: begin
              st.pulse_count = '0;
              st.act = '0;
              st.act[wcs_pkg::ACT_VALVE] = 1'b1;
              if (st.code == wcs_pkg::PH_FILL_WASH) begin
                st.act[wcs_pkg::ACT_POWDER] = 1'b1;
                st.powder_active = 1'b1;
                st.powder_elapsed = '0;
              end else begin
                st.powder_active = 1'b0;
              end
            end
            wcs_pkg::KIND_AGITATE: begin
              st.act = '0;
              st.act[wcs_pkg::ACT_MOTOR] = 1'b1;
            end
            default: begin
              st.act = '0;
              st.act[wcs_pkg::ACT_PUMP] = 1'b1;
            end
          endcase
          st.entered = 1'b1;
        end
        // timeout, or pulse threshold on a fill
        done = (CMP_W'(el) >= CMP_W'(st.limit)) ||
               ((kind == wcs_pkg::KIND_FILL) &&
                (st.pulse_count >= cfg.fill_pulse_threshold));
        if (done) begin
          st.act = '0;
          st.powder_active = 1'b0;
          st.code = st.code + 1'b1;
          st.entered = 1'b0;
          adv = 1'b1;
        end
      end
    end
  end

  assign state_next         = st;
  assign elapsed_next       = el;
  assign res.act            = st.act;
  assign res.phase          = st.code;
  assign res.phase_advanced = adv;

endmodule

`default_nettype wire

/* sv/wash_cycle_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// wash_cycle_sequencer_unit: 13-phase washing machine cycle sequencer
//
//   channel  dir  handshake      contents
//   tick     in   valid/ready    paused, reed_pulses, load_phase, new_phase
//   result   out  valid/ready    pump/motor/valve/powder drives, phase, advanced
//   cfg      in   cfg_we only    cfg_index, cfg_data (8 configuration registers)
//
// One tick per clock while the result is not stalled: tick register, one pass of
// step logic, result register; result valid is set as the result register loads.
// A stalled result holds the pipeline; the tick register still drains into
// the result register whenever that register is empty or being taken.
// Synchronous reset clears the sequencer to idle and loads the default timing.
// ----------------------------------------------------------------------------
`default_nettype none

module wash_cycle_sequencer_unit #(
  parameter int unsigned TIME_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  wcs_tick_if.sink                          tick,
  wcs_result_if.source                      result,
  input  wire logic                         cfg_we,
  input  wire logic [wcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wcs_pkg::CFG_W-1:0]    cfg_data
);

  wcs_pkg::cfg_t        cfg;
  wcs_pkg::tick_t       tick_q;
  logic                 tick_vld;
  wcs_pkg::result_t     res_q;
  logic                 res_vld;
  wcs_pkg::seq_state_t  state;
  logic [TIME_BITS-1:0] elapsed;
  wcs_pkg::seq_state_t  state_next;
  logic [TIME_BITS-1:0] elapsed_next;
  wcs_pkg::result_t     res_next;
  logic                 advance;

  // tick register moves into the result register
  assign advance    = tick_vld && (!res_vld || result.ready);
  assign tick.ready = !tick_vld || advance;

  wcs_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .state        (state),
    .elapsed      (elapsed),
    .tick         (tick_q),
    .cfg          (cfg),
    .state_next   (state_next),
    .elapsed_next (elapsed_next),
    .res          (res_next)
  );

  // control, sequencer state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_vld                 <= 1'b0;
      res_vld                  <= 1'b0;
      state                    <= '0;
      elapsed                  <= '0;
      cfg.drain_time           <= 24'd60000;
      cfg.fill_timeout         <= 24'd120000;
      cfg.prewash_time         <= 24'd300000;
      cfg.wash_time            <= 24'd1200000;
      cfg.rinse_one_time       <= 24'd300000;
      cfg.rinse_two_time       <= 24'd300000;
      cfg.fill_pulse_threshold <= 16'd100;
      cfg.powder_time          <= 16'd1000;
    end else begin
      if (tick.ready) tick_vld <= tick.valid;
      if (advance) begin
        state   <= state_next;
        elapsed <= elapsed_next;
        res_vld <= 1'b1;
      end else if (result.ready) begin
        res_vld <= 1'b0;
      end
      // register write
      if (cfg_we) begin
        unique case (cfg_index)
          wcs_pkg::REG_DRAIN_TIME:     cfg.drain_time     <= cfg_data;
          wcs_pkg::REG_FILL_TIMEOUT:   cfg.fill_timeout   <= cfg_data;
          wcs_pkg::REG_PREWASH_TIME:   cfg.prewash_time   <= cfg_data;
          wcs_pkg::REG_WASH_TIME:      cfg.wash_time      <= cfg_data;
          wcs_pkg::REG_RINSE_ONE_TIME: cfg.rinse_one_time <= cfg_data;
          wcs_pkg::REG_RINSE_TWO_TIME: cfg.rinse_two_time <= cfg_data;
          wcs_pkg::REG_FILL_THRESHOLD:
            cfg.fill_pulse_threshold <= cfg_data[wcs_pkg::CNT_W-1:0];
          wcs_pkg::REG_POWDER_TIME:
            cfg.powder_time <= cfg_data[wcs_pkg::CNT_W-1:0];
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_q.paused      <= tick.paused;
      tick_q.reed_pulses <= tick.reed_pulses;
      tick_q.load_phase  <= tick.load_phase;
      tick_q.new_phase   <= tick.new_phase;
    end
    if (advance) res_q <= res_next;
  end

  // result channel
  assign result.valid          = res_vld;
  assign result.pump_on        = res_q.act[wcs_pkg::ACT_PUMP];
  assign result.motor_on       = res_q.act[wcs_pkg::ACT_MOTOR];
  assign result.valve_on       = res_q.act[wcs_pkg::ACT_VALVE];
  assign result.powder_on      = res_q.act[wcs_pkg::ACT_POWDER];
  assign result.phase          = res_q.phase;
  assign result.phase_advanced = res_q.phase_advanced;

endmodule

`default_nettype wire
